// ===== rtl/core/gpt_pkg.sv =====
// Shared constants for the grid path tracer: grid size, cell kinds, actions, headings.
package gpt_pkg;

    localparam int GRID_W   = 32;
    localparam int GRID_H   = 32;
    localparam int COORD_W  = 5;
    localparam int ADDR_W   = $clog2(GRID_W * GRID_H);
    localparam int CELLS    = GRID_W * GRID_H;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_PATH  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_ADVANCE = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
        cell_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(GRID_W) + ADDR_W'(x));
    endfunction

endpackage

// ===== rtl/core/grid_path_tracer.sv =====
// Grid path tracer: cell-kind grid memory with a tracer that follows a 4-connected path.
//
// Each input word is one action and gives exactly one output word with the tracer's
// position, heading, a moved flag and an at-end flag. The block works on one word at a
// time under a small sequencer around a grid memory with a registered read, so a
// neighbour probe inside the grid reads the cell and then checks it, and one outside the
// grid or on the reverse heading is skipped with no read. A write stores the cell, then
// reads the current cell; a start makes up to four neighbour probes, then a read of the
// start cell; an advance reads the current cell, then makes up to four neighbour probes
// with the reverse heading skipped; any other action reads the current cell. Each then
// loads the output register and goes idle to take the next word, which is taken while
// the previous result still waits on the output side. After reset the grid memory is
// cleared one cell per cycle, so the input stays not ready until all 1024 cells are done.
module grid_path_tracer
    import gpt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] action, [6:2] cell_x, [11:7] cell_y, [13:12] cell_kind, [15:14] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [4:0] pos_x, [9:5] pos_y, [11:10] heading, [12] moved, [13] at_end, [15:14] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_HERE_RD,
        S_HERE_CHK,
        S_PROBE,
        S_CHECK,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [1:0]           r_mem [CELLS];
    logic [1:0]           r_rdata;

    logic [COORD_W-1:0]   r_x, r_y, r_start_x, r_start_y, r_cur_x, r_cur_y;
    logic [1:0]           r_kind, r_heading, r_dir, r_rev, r_cnt;
    logic                 r_pre, r_adv, r_moved, r_at_end;
    logic                 r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;

    logic                 w_accept;
    logic                 w_wr_ok;
    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [1:0]           w_wdata;
    logic [ADDR_W-1:0]    w_raddr;
    logic                 w_nbr_ok;
    logic [COORD_W-1:0]   w_nbr_x, w_nbr_y;
    logic                 w_skip;
    logic                 w_hit;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign w_wr_ok = (32'(r_x) < GRID_W) && (32'(r_y) < GRID_H);
    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_WRITE) && w_wr_ok);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : cell_addr(r_x, r_y);
    assign w_wdata = (r_state == S_CLEAR) ? KIND_OTHER : r_kind;
    assign w_raddr = (r_state == S_HERE_RD) ? cell_addr(r_cur_x, r_cur_y)
                                            : cell_addr(w_nbr_x, w_nbr_y);

    always_comb begin
        w_nbr_x  = r_cur_x;
        w_nbr_y  = r_cur_y;
        w_nbr_ok = 1'b0;
        case (r_dir)
            DIR_UP: begin
                w_nbr_ok = (r_cur_y != '0);
                w_nbr_y  = r_cur_y - COORD_W'(1);
            end
            DIR_LEFT: begin
                w_nbr_ok = (r_cur_x != '0);
                w_nbr_x  = r_cur_x - COORD_W'(1);
            end
            DIR_DOWN: begin
                w_nbr_ok = (32'(r_cur_y) < GRID_H - 1);
                w_nbr_y  = r_cur_y + COORD_W'(1);
            end
            DIR_RIGHT: begin
                w_nbr_ok = (32'(r_cur_x) < GRID_W - 1);
                w_nbr_x  = r_cur_x + COORD_W'(1);
            end
            default: begin
                w_nbr_ok = 1'b0;
            end
        endcase
    end

    assign w_skip = !w_nbr_ok || (r_adv && (r_dir == r_rev));
    assign w_hit  = r_adv ? ((r_rdata == KIND_PATH) || (r_rdata == KIND_END))
                          : (r_rdata == KIND_PATH);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_heading  <= DIR_DOWN;
            r_dir      <= DIR_UP;
            r_rev      <= DIR_UP;
            r_cnt      <= '0;
            r_pre      <= 1'b0;
            r_adv      <= 1'b0;
            r_moved    <= 1'b0;
            r_at_end   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (32'(r_clr_addr) == CELLS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_x     <= s_axis_tdata[6:2];
                        r_y     <= s_axis_tdata[11:7];
                        r_kind  <= s_axis_tdata[13:12];
                        r_moved <= 1'b0;
                        r_cnt   <= '0;
                        r_adv   <= 1'b0;
                        r_pre   <= 1'b0;
                        case (s_axis_tdata[1:0])
                            ACT_WRITE: begin
                                r_state <= S_WRITE;
                            end
                            ACT_START: begin
                                r_cur_x   <= r_start_x;
                                r_cur_y   <= r_start_y;
                                r_heading <= DIR_DOWN;
                                r_dir     <= DIR_LEFT;
                                r_state   <= S_PROBE;
                            end
                            ACT_ADVANCE: begin
                                r_pre   <= 1'b1;
                                r_state <= S_HERE_RD;
                            end
                            default: begin
                                r_state <= S_HERE_RD;
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    if (w_wr_ok && (r_kind == KIND_START)) begin
                        r_start_x <= r_x;
                        r_start_y <= r_y;
                    end
                    r_state <= S_HERE_RD;
                end
                S_HERE_RD: begin
                    r_state <= S_HERE_CHK;
                end
                S_HERE_CHK: begin
                    if (r_pre) begin
                        r_pre <= 1'b0;
                        if (r_rdata == KIND_END) begin
                            r_at_end <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_adv   <= 1'b1;
                            r_dir   <= r_heading;
                            r_rev   <= r_heading + 2'd2;
                            r_state <= S_PROBE;
                        end
                    end else begin
                        r_at_end <= (r_rdata == KIND_END);
                        r_state  <= S_OUT;
                    end
                end
                S_PROBE: begin
                    if (!w_skip) begin
                        r_state <= S_CHECK;
                    end else if (r_cnt == 2'd3) begin
                        r_at_end <= 1'b0;
                        r_state  <= r_adv ? S_OUT : S_HERE_RD;
                    end else begin
                        r_cnt <= r_cnt + 2'd1;
                        r_dir <= r_dir + 2'd1;
                    end
                end
                S_CHECK: begin
                    if (w_hit) begin
                        r_heading <= r_dir;
                        if (r_adv) begin
                            r_cur_x  <= w_nbr_x;
                            r_cur_y  <= w_nbr_y;
                            r_moved  <= 1'b1;
                            r_at_end <= (r_rdata == KIND_END);
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_HERE_RD;
                        end
                    end else if (r_cnt == 2'd3) begin
                        r_at_end <= 1'b0;
                        r_state  <= r_adv ? S_OUT : S_HERE_RD;
                    end else begin
                        r_cnt   <= r_cnt + 2'd1;
                        r_dir   <= r_dir + 2'd1;
                        r_state <= S_PROBE;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {2'b00, r_at_end, r_moved, r_heading, r_cur_y, r_cur_x};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR))
        else $error("grid clear not started after reset");

    a_write_states : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_CLEAR) || (r_state == S_WRITE)))
        else $error("grid written outside clear or write");

    a_check_follows_probe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> ($past(r_state) == S_PROBE))
        else $error("neighbour checked without a probe read");

    a_moved_only_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_moved) |-> r_adv)
        else $error("moved flag set outside an advance");

endmodule

// ===== tb/sv/grid_path_tracer_tb.sv =====
// Self-checking stream testbench for the grid path tracer: directed table, random path walks.
`timescale 1ns / 100ps

module grid_path_tracer_tb;
    import gpt_pkg::*;

    localparam logic [1:0] ACT_IDLE = 2'd3;

    typedef struct packed {
        logic [1:0]         pad;
        logic [1:0]         cell_kind;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_x;
        logic [1:0]         action;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]         pad;
        logic               at_end;
        logic               moved;
        logic [1:0]         heading;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
    } t_tracer_word;

    typedef struct {
        t_cmd_word    cmd;
        bit           typed;
        t_tracer_word want;
    } t_cmd_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [1:0] action, [6:2] cell_x, [11:7] cell_y, [13:12] cell_kind, [15:14] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [4:0] pos_x, [9:5] pos_y, [11:10] heading, [12] moved, [13] at_end, [15:14] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    grid_path_tracer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [1:0]         grid_m [0:CELLS-1];
    logic [COORD_W-1:0] start_x, start_y;
    logic [COORD_W-1:0] tracer_x, tracer_y;
    logic [1:0]         tracer_head;

    t_tracer_word tracer_reports_q[$];
    t_cmd_row     cmd_rows[$];
    int           sender_gap_pct;
    int           receiver_stall_pct;
    int           words_sent;
    int           word_mismatches;

    function automatic int cell_index(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        return int'(y) * GRID_W + int'(x);
    endfunction

    function automatic logic [1:0] neighbor_kind(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y,
                                                 input logic [1:0] dir,
                                                 output logic [COORD_W-1:0] nx,
                                                 output logic [COORD_W-1:0] ny);
        int tx;
        int ty;
        tx = int'(x);
        ty = int'(y);
        case (dir)
            DIR_UP:   ty = ty - 1;
            DIR_LEFT: tx = tx - 1;
            DIR_DOWN: ty = ty + 1;
            default:  tx = tx + 1;
        endcase
        nx = tx[COORD_W-1:0];
        ny = ty[COORD_W-1:0];
        if (tx < 0 || ty < 0 || tx >= GRID_W || ty >= GRID_H)
            return KIND_OTHER;
        return grid_m[ty * GRID_W + tx];
    endfunction

    function automatic t_tracer_word trace_action(input t_cmd_word cmd);
        logic [1:0]         first_try [4];
        logic [1:0]         dir;
        logic [1:0]         back;
        logic [1:0]         kind;
        logic [COORD_W-1:0] nx, ny;
        logic               stepped;
        logic               found;
        t_tracer_word       rpt;
        first_try = '{DIR_LEFT, DIR_DOWN, DIR_RIGHT, DIR_UP};
        stepped = 1'b0;
        found = 1'b0;
        case (cmd.action)
            ACT_WRITE: begin
                grid_m[cell_index(cmd.cell_x, cmd.cell_y)] = cmd.cell_kind;
                if (cmd.cell_kind == KIND_START) begin
                    start_x = cmd.cell_x;
                    start_y = cmd.cell_y;
                end
            end
            ACT_START: begin
                tracer_x = start_x;
                tracer_y = start_y;
                tracer_head = DIR_DOWN;
                for (int i = 0; i < 4; i++) begin
                    if (!found && neighbor_kind(tracer_x, tracer_y, first_try[i], nx, ny)
                            == KIND_PATH) begin
                        tracer_head = first_try[i];
                        found = 1'b1;
                    end
                end
            end
            ACT_ADVANCE: begin
                if (grid_m[cell_index(tracer_x, tracer_y)] != KIND_END) begin
                    dir = tracer_head;
                    back = tracer_head + 2'd2;
                    for (int i = 0; i < 4; i++) begin
                        if (!stepped && dir != back) begin
                            kind = neighbor_kind(tracer_x, tracer_y, dir, nx, ny);
                            if (kind == KIND_PATH || kind == KIND_END) begin
                                tracer_x = nx;
                                tracer_y = ny;
                                tracer_head = dir;
                                stepped = 1'b1;
                            end
                        end
                        dir = dir + 2'd1;
                    end
                end
            end
            default: ;
        endcase
        rpt = '0;
        rpt.pos_x = tracer_x;
        rpt.pos_y = tracer_y;
        rpt.heading = tracer_head;
        rpt.moved = stepped;
        rpt.at_end = (grid_m[cell_index(tracer_x, tracer_y)] == KIND_END);
        return rpt;
    endfunction

    function automatic t_cmd_word make_cmd(input logic [1:0] action, input int x, input int y,
                                           input logic [1:0] kind);
        t_cmd_word cmd;
        cmd = '0;
        cmd.action = action;
        cmd.cell_x = x[COORD_W-1:0];
        cmd.cell_y = y[COORD_W-1:0];
        cmd.cell_kind = kind;
        return cmd;
    endfunction

    function automatic t_tracer_word report(input int x, input int y, input logic [1:0] head,
                                            input logic moved, input logic at_end);
        t_tracer_word rpt;
        rpt = '0;
        rpt.pos_x = x[COORD_W-1:0];
        rpt.pos_y = y[COORD_W-1:0];
        rpt.heading = head;
        rpt.moved = moved;
        rpt.at_end = at_end;
        return rpt;
    endfunction

    function automatic void add_row(input logic [1:0] action, input int x, input int y,
                                    input logic [1:0] kind, input bit typed,
                                    input t_tracer_word want);
        t_cmd_row row;
        row.cmd = make_cmd(action, x, y, kind);
        row.typed = typed;
        row.want = want;
        cmd_rows = {cmd_rows, row};
    endfunction

    task automatic send_word(input t_cmd_word cmd, input bit typed, input t_tracer_word want);
        t_tracer_word predicted;
        if (sender_gap_pct != 0 && $urandom_range(1, 100) <= sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = trace_action(cmd);
        if (typed)
            predicted = want;
        tracer_reports_q = {tracer_reports_q, predicted};
        words_sent++;
    endtask

    task automatic send_cmd(input logic [1:0] action, input int x, input int y,
                            input logic [1:0] kind);
        send_word(make_cmd(action, x, y, kind), 1'b0, '0);
    endtask

    task automatic send_noise();
        send_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
                 2'($urandom_range(0, 3)));
    endtask

    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracer_reports_q.size() != 0);
    endtask

    task automatic trace_random_path();
        int         len;
        int         tx, ty;
        int         x, y;
        logic [1:0] dir;
        bit         ended;
        int         xs[$];
        int         ys[$];
        x = $urandom_range(0, 31);
        y = $urandom_range(0, 31);
        if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1) != 0)
                x = ($urandom_range(0, 1) != 0) ? 0 : 31;
            else
                y = ($urandom_range(0, 1) != 0) ? 0 : 31;
        end
        send_cmd(ACT_WRITE, x, y, KIND_START);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        ended = ($urandom_range(0, 4) != 0);
        for (int i = 0; i < len; i++) begin
            dir = 2'($urandom_range(0, 3));
            do begin
                tx = x;
                ty = y;
                case (dir)
                    DIR_UP:   ty = ty - 1;
                    DIR_LEFT: tx = tx - 1;
                    DIR_DOWN: ty = ty + 1;
                    default:  tx = tx + 1;
                endcase
                dir = dir + 2'd1;
            end while (tx < 0 || ty < 0 || tx >= GRID_W || ty >= GRID_H);
            x = tx;
            y = ty;
            xs = {xs, x};
            ys = {ys, y};
            send_cmd(ACT_WRITE, x, y, (i == len - 1 && ended) ? KIND_END : KIND_PATH);
        end
        if ($urandom_range(0, 5) != 0)
            send_cmd(ACT_START, $urandom_range(0, 31), $urandom_range(0, 31),
                     2'($urandom_range(0, 3)));
        repeat (len + $urandom_range(0, 4)) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            send_cmd(ACT_ADVANCE, $urandom_range(0, 31), $urandom_range(0, 31),
                     2'($urandom_range(0, 3)));
        end
        if ($urandom_range(0, 1) != 0) begin
            foreach (xs[i])
                send_cmd(ACT_WRITE, xs[i], ys[i], KIND_OTHER);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            word_mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("grid_path_tracer regression: fail");
        $finish;
    end

    initial begin : rx_stalls
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && receiver_stall_pct != 0
                    && $urandom_range(1, 100) <= receiver_stall_pct)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_tracer_word got;
        t_tracer_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (tracer_reports_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                word_mismatches++;
            end else begin
                want = tracer_reports_q.pop_front();
                check_field("pos_x", int'(want.pos_x), int'(got.pos_x));
                check_field("pos_y", int'(want.pos_y), int'(got.pos_y));
                check_field("heading", int'(want.heading), int'(got.heading));
                check_field("moved", int'(want.moved), int'(got.moved));
                check_field("at_end", int'(want.at_end), int'(got.at_end));
            end
        end
    end

    initial begin
        int stall_pick;
        sender_gap_pct = 10;
        receiver_stall_pct = 5;
        words_sent = 0;
        word_mismatches = 0;
        foreach (grid_m[i])
            grid_m[i] = KIND_OTHER;
        start_x = '0;
        start_y = '0;
        tracer_x = '0;
        tracer_y = '0;
        tracer_head = DIR_DOWN;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(ACT_IDLE, 0, 0, KIND_OTHER, 1'b1, report(0, 0, DIR_DOWN, 1'b0, 1'b0));
        add_row(ACT_ADVANCE, 0, 0, KIND_OTHER, 1'b1, report(0, 0, DIR_DOWN, 1'b0, 1'b0));
        add_row(ACT_START, 0, 0, KIND_OTHER, 1'b1, report(0, 0, DIR_DOWN, 1'b0, 1'b0));
        add_row(ACT_WRITE, 31, 31, KIND_END, 1'b1, report(0, 0, DIR_DOWN, 1'b0, 1'b0));
        add_row(ACT_WRITE, 31, 30, KIND_START, 1'b1, report(0, 0, DIR_DOWN, 1'b0, 1'b0));
        add_row(ACT_WRITE, 30, 30, KIND_PATH, 1'b1, report(0, 0, DIR_DOWN, 1'b0, 1'b0));
        add_row(ACT_START, 0, 0, KIND_OTHER, 1'b1, report(31, 30, DIR_LEFT, 1'b0, 1'b0));
        add_row(ACT_ADVANCE, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_WRITE, 30, 31, KIND_END, 1'b0, '0);
        add_row(ACT_ADVANCE, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_ADVANCE, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_WRITE, 0, 0, KIND_START, 1'b0, '0);
        add_row(ACT_WRITE, 1, 0, KIND_PATH, 1'b0, '0);
        add_row(ACT_START, 31, 31, KIND_END, 1'b0, '0);
        add_row(ACT_ADVANCE, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_ADVANCE, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_WRITE, 0, 0, KIND_END, 1'b0, '0);
        add_row(ACT_START, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_ADVANCE, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_WRITE, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_WRITE, 0, 1, KIND_PATH, 1'b0, '0);
        add_row(ACT_START, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_ADVANCE, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_ADVANCE, 0, 0, KIND_OTHER, 1'b0, '0);
        add_row(ACT_IDLE, 31, 31, KIND_END, 1'b0, '0);

        foreach (cmd_rows[i])
            send_word(cmd_rows[i].cmd, cmd_rows[i].typed, cmd_rows[i].want);
        drain_reports();

        while (words_sent < 1450) begin
            if (words_sent > 1300 || $urandom_range(0, 3) == 0) begin
                sender_gap_pct = 0;
                receiver_stall_pct = 0;
            end else begin
                sender_gap_pct = $urandom_range(5, 40);
                receiver_stall_pct = $urandom_range(2, 12);
            end
            stall_pick = $urandom_range(0, 9);
            case (stall_pick)
                0, 1: begin
                    repeat ($urandom_range(1, 6)) send_noise();
                end
                2: begin
                    drain_reports();
                    trace_random_path();
                end
                default: begin
                    trace_random_path();
                end
            endcase
        end

        drain_reports();
        repeat (16) @(posedge i_clk);
        if (word_mismatches == 0) begin
            $display("grid_path_tracer regression: pass");
        end else begin
            $display("grid_path_tracer regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gpt_pkg.sv
rtl/core/grid_path_tracer.sv
tb/sv/grid_path_tracer_tb.sv
